@@ rtl/rzct_pkg.sv @@
// Shared constants and types for the rising zero-cross trigger search block.
package rzct_pkg;

    localparam int DEPTH     = 8192;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int RANGE_W   = ADDR_W + 1;
    localparam int SW        = 16;
    localparam int WIN_W     = 9;
    localparam int WIN_M1_W  = 8;
    localparam int THR_W     = 15;
    localparam int CFG_W     = 15;
    localparam int FRAC_W    = 8;
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(4);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(256);
    localparam logic [WIN_W-1:0] PW_RESET  = WIN_W'(60);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(328);

    localparam logic CFG_PEAK_WINDOW   = 1'b0;
    localparam logic CFG_AMP_THRESHOLD = 1'b1;

    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_RD_CUR  = 6'b000010,
        ST_RD_PREV = 6'b000100,
        ST_PEAK    = 6'b001000,
        ST_DIV     = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

endpackage

@@ rtl/rising_zero_cross_trigger_search.sv @@
// Top level: ring sample store with backward rising zero-cross trigger search.
//
// Input channel (in_valid/in_stall) carries cmd, sample, target, search_range.
// A push (cmd 0) writes sample at the write pointer; pushes stream one per
// cycle while no search runs and give no result. A search (cmd 1) gives one
// result on the output channel (out_valid/out_stall): found, position_int and
// position_frac. While a search runs, in_stall is high.
// A search walks back from target with one store read per position, and for
// every crossing that is checked reads each sample of the clamped peak
// window; when a crossing qualifies, a shift-subtract divider gives the
// fraction. A crossing exactly at zero skips the divider and a zero range
// goes straight to the result. All these reads share the single read port of
// the sample memory. A finished result sits in the output register; pushes
// and a new search are taken while it waits, and a second result waits in
// its final state until the receiver takes the first. Reset: write pointer
// to zero, registers to their defaults, output empty. Entries not yet written
// since reset read as zero, tracked by the write pointer and a wrapped flag.
// The user must see that configuration is written only while idle; the block
// itself does not enforce this.
module rising_zero_cross_trigger_search
    import rzct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic signed [SW-1:0] sample,
    input  logic [ADDR_W-1:0]   target,
    input  logic [RANGE_W-1:0]  search_range,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [ADDR_W-1:0]   position_int,
    output logic [FRAC_W-1:0]   position_frac,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [SW-1:0] mem [DEPTH];

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    wp_reg;
    logic                 wrapped_reg;
    logic [WIN_W-1:0]     pw_reg;
    logic [THR_W-1:0]     thr_reg;

    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [RANGE_W-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [SW-1:0]        prev_reg, prev_next;
    logic [WIN_M1_W-1:0]  winm1_reg, winm1_next;
    logic [WIN_M1_W-1:0]  rcnt_reg, rcnt_next;
    logic [SW-1:0]        peak_reg, peak_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]        den_reg, den_next;
    logic [FRAC_W-1:0]    q_reg, q_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                 found_reg, found_next;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [ADDR_W-1:0]    out_pos_reg;
    logic [FRAC_W-1:0]    out_frac_reg;

    logic [SW-1:0]        rd_data_reg;
    logic                 rd_valid_reg;
    logic [SW-1:0]        rd_eff;
    logic [ADDR_W-1:0]    raddr;

    logic                 in_acc;
    logic                 push_acc;
    logic [RANGE_W-1:0]   range_cap;
    logic [WIN_M1_W-1:0]  win_m1;
    logic [SW-1:0]        mag;
    logic [SW-1:0]        peak_upd;
    logic                 crossing;
    logic [SW-1:0]        neg_prev;
    logic [SW:0]          rem_dbl;
    logic                 rem_ge;
    logic                 load_out;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign push_acc = in_acc && (cmd == CMD_PUSH);

    assign range_cap = (search_range > RANGE_W'(DEPTH)) ? RANGE_W'(DEPTH) : search_range;

    always_comb
    begin
        if (pw_reg < WIN_MIN)
        begin
            win_m1 = WIN_M1_W'(WIN_MIN - WIN_W'(1));
        end
        else if (pw_reg > WIN_MAX)
        begin
            win_m1 = WIN_M1_W'(WIN_MAX - WIN_W'(1));
        end
        else
        begin
            win_m1 = WIN_M1_W'(pw_reg - WIN_W'(1));
        end
    end

    // never-written entries read as zero
    assign rd_eff   = rd_valid_reg ? rd_data_reg : '0;
    assign mag      = rd_eff[SW-1] ? (~rd_eff + SW'(1)) : rd_eff;
    assign peak_upd = (mag > peak_reg) ? mag : peak_reg;
    assign crossing = !cur_reg[SW-1] && rd_eff[SW-1];
    assign neg_prev = ~prev_reg + SW'(1);
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_ge   = rem_dbl >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        winm1_next = winm1_reg;
        rcnt_next  = rcnt_reg;
        peak_next  = peak_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        dcnt_next  = dcnt_reg;
        found_next = found_reg;
        raddr      = pos_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = target;
                if (in_acc && (cmd == CMD_SEARCH))
                begin
                    pos_next   = target;
                    cnt_next   = range_cap;
                    winm1_next = win_m1;
                    found_next = 1'b0;
                    q_next     = '0;
                    state_next = (range_cap == '0) ? ST_DONE : ST_RD_CUR;
                end
            end
            ST_RD_CUR:
            begin
                cur_next   = rd_eff;
                raddr      = pos_reg - ADDR_W'(1);
                state_next = ST_RD_PREV;
            end
            ST_RD_PREV:
            begin
                if (crossing)
                begin
                    prev_next  = rd_eff;
                    raddr      = pos_reg;
                    rcnt_next  = '0;
                    peak_next  = '0;
                    state_next = ST_PEAK;
                end
                else
                begin
                    cur_next = rd_eff;
                    raddr    = pos_reg - ADDR_W'(2);
                    if (cnt_reg == RANGE_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next = pos_reg - ADDR_W'(1);
                        cnt_next = cnt_reg - RANGE_W'(1);
                    end
                end
            end
            ST_PEAK:
            begin
                peak_next = peak_upd;
                if (rcnt_reg == winm1_reg)
                begin
                    if (peak_upd > SW'(thr_reg))
                    begin
                        found_next = 1'b1;
                        rem_next   = neg_prev;
                        den_next   = cur_reg + neg_prev;
                        dcnt_next  = '0;
                        if (cur_reg == '0)
                        begin
                            // exact zero: fraction would be 256
                            q_next     = '1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            q_next     = '0;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        cur_next = prev_reg;
                        raddr    = pos_reg - ADDR_W'(2);
                        if (cnt_reg == RANGE_W'(1))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = pos_reg - ADDR_W'(1);
                            cnt_next   = cnt_reg - RANGE_W'(1);
                            state_next = ST_RD_PREV;
                        end
                    end
                end
                else
                begin
                    rcnt_next = rcnt_reg + WIN_M1_W'(1);
                    raddr     = pos_reg + ADDR_W'(rcnt_reg) + ADDR_W'(1);
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                q_next    = {q_reg[FRAC_W-2:0], rem_ge};
                rem_next  = rem_ge ? SW'(rem_dbl - {1'b0, den_reg}) : rem_dbl[SW-1:0];
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_CNT_W'(FRAC_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            mem[wp_reg] <= sample;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            pw_reg        <= PW_RESET;
            thr_reg       <= THR_RESET;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= wrapped_reg || (raddr < wp_reg);
            if (push_acc)
            begin
                wp_reg <= wp_reg + ADDR_W'(1);
                if (wp_reg == ADDR_W'(DEPTH - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PEAK_WINDOW:   pw_reg  <= cfg_data[WIN_W-1:0];
                    CFG_AMP_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    default:           ;
                endcase
            end
            out_valid_reg <= load_out || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        winm1_reg <= winm1_next;
        rcnt_reg  <= rcnt_next;
        peak_reg  <= peak_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        dcnt_reg  <= dcnt_next;
        found_reg <= found_next;
        if (load_out)
        begin
            out_found_reg <= found_reg;
            out_pos_reg   <= found_reg ? (pos_reg - ADDR_W'(1)) : '0;
            out_frac_reg  <= found_reg ? q_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_found_reg;
    assign position_int  = out_pos_reg;
    assign position_frac = out_frac_reg;

endmodule

@@ rtl/rzct_checker.sv @@
// Port-level checks for the trigger search block, bound to the top level.
module rzct_checker
    import rzct_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 cmd,
    input logic signed [SW-1:0] sample,
    input logic [ADDR_W-1:0]    target,
    input logic [RANGE_W-1:0]   search_range,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 found,
    input logic [ADDR_W-1:0]    position_int,
    input logic [FRAC_W-1:0]    position_frac,
    input logic                 cfg_we,
    input logic                 cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found)
            && $stable(position_int) && $stable(position_frac))
        else $error("stalled result changed");

    // a miss reports zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position_int == '0 && position_frac == '0)
        else $error("miss result not zero");

    // input closes only after a search transfer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall && cmd == CMD_SEARCH))
        else $error("input stalled without a search");

    // new results come only from a running search
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared outside a search");

endmodule

bind rising_zero_cross_trigger_search rzct_checker u_rzct_checker (.*);

@@ dv/trigger_search_checker.sv @@
// Checker for the trigger search block: tracks the sample ring, predicts each search, compares.
module trigger_search_checker
    import rzct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 cmd,
    input  logic signed [SW-1:0] sample,
    input  logic [ADDR_W-1:0]    target,
    input  logic [RANGE_W-1:0]   search_range,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 found,
    input  logic [ADDR_W-1:0]    position_int,
    input  logic [FRAC_W-1:0]    position_frac,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] pos_int;
        logic [FRAC_W-1:0] pos_frac;
    } trigger_t;

    logic signed [SW-1:0] ring [DEPTH];
    logic [ADDR_W-1:0]    wr_ptr;
    logic [WIN_W-1:0]     peak_window;
    logic [THR_W-1:0]     amp_threshold;
    trigger_t             expected_triggers [$];

    // Walk back from start; first rising crossing whose peak from the current
    // sample onward beats the threshold wins.
    function automatic trigger_t find_trigger(input logic [ADDR_W-1:0]  start,
                                              input logic [RANGE_W-1:0] span);
        trigger_t             hit;
        int                   steps;
        int                   win;
        int                   peak;
        int                   mag;
        int                   quot;
        logic [ADDR_W-1:0]    pos;
        logic [ADDR_W-1:0]    prv;
        logic signed [SW-1:0] pv;
        logic signed [SW-1:0] cv;
        hit = '0;
        steps = (span > DEPTH) ? DEPTH : int'(span);
        if (peak_window < WIN_MIN)
            win = int'(WIN_MIN);
        else if (peak_window > WIN_MAX)
            win = int'(WIN_MAX);
        else
            win = int'(peak_window);
        for (int i = 0; i < steps; i++)
        begin
            pos = start - ADDR_W'(i);
            prv = pos - 1'b1;
            pv  = ring[prv];
            cv  = ring[pos];
            if (pv < 0 && cv >= 0)
            begin
                peak = 0;
                for (int j = 0; j < win; j++)
                begin
                    mag = int'(ring[pos + ADDR_W'(j)]);
                    if (mag < 0)
                        mag = -mag;
                    if (mag > peak)
                        peak = mag;
                end
                if (peak > int'(amp_threshold))
                begin
                    quot = (-int'(pv) * 256) / (int'(cv) - int'(pv));
                    hit.found    = 1'b1;
                    hit.pos_int  = prv;
                    // crossing landing exactly on zero gives 256
                    hit.pos_frac = (quot > 255) ? FRAC_W'(255) : FRAC_W'(quot);
                    return hit;
                end
            end
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        trigger_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                ring[k] = '0;
            wr_ptr        = '0;
            peak_window   = PW_RESET;
            amp_threshold = THR_RESET;
            expected_triggers.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PEAK_WINDOW)
                    peak_window = cfg_data[WIN_W-1:0];
                else if (cfg_index == CFG_AMP_THRESHOLD)
                    amp_threshold = cfg_data[THR_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_triggers.size() == 0)
                begin
                    $error("unexpected result transfer: found %0d position_int %0d position_frac %0d",
                           found, position_int, position_frac);
                    errors++;
                end
                else
                begin
                    want = expected_triggers.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, found);
                        errors++;
                    end
                    if (position_int !== want.pos_int)
                    begin
                        $error("position_int: expected %0d, actual %0d", want.pos_int,
                               position_int);
                        errors++;
                    end
                    if (position_frac !== want.pos_frac)
                    begin
                        $error("position_frac: expected %0d, actual %0d", want.pos_frac,
                               position_frac);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_PUSH)
                begin
                    ring[wr_ptr] = sample;
                    wr_ptr = wr_ptr + 1'b1;
                end
                else
                    expected_triggers.push_back(find_trigger(target, search_range));
            end
            pending = expected_triggers.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the trigger search testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
    import rzct_pkg::*;

    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 198;
    localparam int RUN_LIMIT     = 6_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic signed [SW-1:0] sample;
    logic [ADDR_W-1:0]    target;
    logic [RANGE_W-1:0]   search_range;
    logic                 out_valid;
    logic                 out_stall;
    logic                 found;
    logic [ADDR_W-1:0]    position_int;
    logic [FRAC_W-1:0]    position_frac;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;

    int                   tx_idle;
    int                   rx_idle;
    int                   hold_req;
    int                   hold_done;
    int                   items_sent;
    logic [ADDR_W-1:0]    wr_ptr;

    rising_zero_cross_trigger_search u_dut (.*);

    trigger_search_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stall, or a long hold-off when requested.
    initial
    begin
        out_stall = 1'b0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done++;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    task automatic set_mode(input int mode);
        case (mode)
            0:
            begin
                tx_idle = 9;
                rx_idle = 66;
            end
            1:
            begin
                tx_idle = 66;
                rx_idle = 9;
            end
            default:
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
        endcase
    endtask

    task automatic send_item(input logic                 op,
                             input logic signed [SW-1:0] smp,
                             input logic [ADDR_W-1:0]    tgt,
                             input logic [RANGE_W-1:0]   span);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        sample       <= smp;
        target       <= tgt;
        search_range <= span;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == CMD_PUSH)
            wr_ptr = wr_ptr + 1'b1;
        items_sent++;
    endtask

    task automatic push(input int value);
        send_item(CMD_PUSH, SW'(value), ADDR_W'($urandom), RANGE_W'($urandom));
    endtask

    task automatic search(input logic [ADDR_W-1:0] tgt, input logic [RANGE_W-1:0] span);
        send_item(CMD_SEARCH, SW'($urandom), tgt, span);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering and wait until every search result has been taken.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Negative run, then a non-negative run: one rising crossing of random size.
    task automatic wave_segment();
        int amp;
        int neg_len;
        int pos_len;
        amp     = ($urandom_range(9) < 3) ? $urandom_range(600, 0) : $urandom_range(32767, 0);
        neg_len = $urandom_range(8, 1);
        pos_len = $urandom_range(24, 1);
        repeat (neg_len) push(-int'($urandom_range(amp + 1, 1)));
        if ($urandom_range(4) == 0)
        begin
            push(0);
            pos_len--;
        end
        repeat (pos_len) push(int'($urandom_range(amp, 0)));
        if ($urandom_range(1) == 1)
            search(wr_ptr - 1'b1 - ADDR_W'($urandom_range(3)), RANGE_W'($urandom_range(48, 1)));
    endtask

    task automatic random_phase(input int quota);
        int start_count;
        int pick;
        start_count = items_sent;
        while (items_sent - start_count < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                wave_segment();
            else if (pick < 85)
                push(int'($urandom_range(65535)));
            else if (pick < 97)
                search(ADDR_W'($urandom), RANGE_W'($urandom_range(96)));
            else
                search(ADDR_W'($urandom), RANGE_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_PUSH;
        sample       = '0;
        target       = '0;
        search_range = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PEAK_WINDOW;
        cfg_data     = '0;
        hold_req     = 0;
        items_sent   = 0;
        wr_ptr       = '0;
        set_mode(0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, register defaults
        search('0, '0);
        search(ADDR_W'(DEPTH - 1), RANGE_W'(DEPTH));
        push(-32768);
        push(32767);
        push(-1);
        push(0);
        push(1000);
        push(-5);
        push(3);
        search(wr_ptr - 1'b1, RANGE_W'(2));
        search(wr_ptr - 1'b1, RANGE_W'(16));
        search(ADDR_W'(1), RANGE_W'(1));
        search('0, RANGE_W'(4));
        search(ADDR_W'(DEPTH - 1), '1);
        push(-32768);
        push(0);
        // peak window starts at the current sample, so this one fails
        search(wr_ptr - 1'b1, RANGE_W'(1));
        push(20000);
        search(wr_ptr - 2'd2, RANGE_W'(1));

        drain();
        write_reg(CFG_PEAK_WINDOW, 4);
        write_reg(CFG_AMP_THRESHOLD, 0);
        random_phase(PHASE_ITEMS);

        drain();
        write_reg(CFG_PEAK_WINDOW, 256);
        write_reg(CFG_AMP_THRESHOLD, 32767);
        random_phase(PHASE_ITEMS);

        drain();
        set_mode(1);
        write_reg(CFG_PEAK_WINDOW, 0);
        write_reg(CFG_AMP_THRESHOLD, 200);
        random_phase(PHASE_ITEMS);

        drain();
        write_reg(CFG_PEAK_WINDOW, 511);
        write_reg(CFG_AMP_THRESHOLD, 1500);
        random_phase(PHASE_ITEMS);

        drain();
        set_mode(2);
        write_reg(CFG_PEAK_WINDOW, int'($urandom_range(511)));
        write_reg(CFG_AMP_THRESHOLD, int'($urandom_range(4000)));
        random_phase(PHASE_ITEMS / 2);
        drain();
        random_phase(PHASE_ITEMS / 2);

        drain();
        write_reg(CFG_PEAK_WINDOW, int'(PW_RESET));
        write_reg(CFG_AMP_THRESHOLD, int'(THR_RESET));
        // receiver holds off while searches pile up and back-pressure the input
        hold_req++;
        repeat (3)
        begin
            wave_segment();
            search(wr_ptr - 1'b1, RANGE_W'(32));
        end
        random_phase(PHASE_ITEMS);

        drain();
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rzct_pkg.sv
rtl/rising_zero_cross_trigger_search.sv
rtl/rzct_checker.sv
dv/trigger_search_checker.sv
dv/testbench.sv
